@@ sv/bcd_alu_pkg.sv @@
// shared types and constants for the eight-bit bcd alu
// no dependencies; used by bcd_alu_addsub, bcd_alu_exec and eight_bit_bcd_alu_core
package bcd_alu_pkg;

    // operation codes
    typedef enum logic [3:0] {
        OP_ADC  = 4'd0,
        OP_SBC  = 4'd1,
        OP_AND  = 4'd2,
        OP_ORA  = 4'd3,
        OP_EOR  = 4'd4,
        OP_ASL  = 4'd5,
        OP_LSR  = 4'd6,
        OP_ROL  = 4'd7,
        OP_ROR  = 4'd8,
        OP_CMP  = 4'd9,
        OP_BIT  = 4'd10,
        OP_INC  = 4'd11,
        OP_DEC  = 4'd12,
        OP_PASS = 4'd13
    } t_alu_op;

    // flag mask bits
    localparam logic [3:0] FLG_C = 4'b0001;
    localparam logic [3:0] FLG_Z = 4'b0010;
    localparam logic [3:0] FLG_V = 4'b0100;
    localparam logic [3:0] FLG_N = 4'b1000;

    // bcd digit limits
    localparam logic [5:0] DIGIT_MAX = 6'd9;
    localparam logic [5:0] DIGIT_ADJ = 6'd6;

    // one input word
    typedef struct packed {
        logic [3:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic       c;
        logic       d;
    } t_alu_in;

    // adder / subtractor outcome
    typedef struct packed {
        logic [7:0] res;
        logic       n;
        logic       z;
        logic       c;
        logic       v;
    } t_arith_res;

    // one result word
    typedef struct packed {
        logic [7:0] res;
        logic       n;
        logic       z;
        logic       c;
        logic       v;
        logic [3:0] mask;
    } t_alu_res;

endpackage

@@ sv/bcd_alu_addsub.sv @@
// add and subtract with carry, binary or packed bcd
// depends on bcd_alu_pkg
module bcd_alu_addsub (
    input  logic                    i_sub,
    input  logic [7:0]              i_a,
    input  logic [7:0]              i_b,
    input  logic                    i_c,
    input  logic                    i_d,
    output bcd_alu_pkg::t_arith_res o_res
);

    logic [8:0] add_bin;
    logic [8:0] sub_bin;
    logic       borrow;
    logic [5:0] add_lo;
    logic [5:0] add_hi;
    logic [7:0] add_mid;
    logic [4:0] sub_lo;
    logic [4:0] sub_hi;

    assign borrow  = ~i_c;
    assign add_bin = {1'b0, i_a} + {1'b0, i_b} + {8'd0, i_c};
    assign sub_bin = {1'b0, i_a} - {1'b0, i_b} - {8'd0, borrow};

    // decimal add: low digit adjust, then high digit adjust
    // the adjusted low digit can reach 37, so its carry is a compare, not bit 4
    always_comb begin
        add_lo = {2'b00, i_a[3:0]} + {2'b00, i_b[3:0]} + {5'd0, i_c};
        if (add_lo > bcd_alu_pkg::DIGIT_MAX) begin
            add_lo = add_lo + bcd_alu_pkg::DIGIT_ADJ;
        end
        add_hi = {2'b00, i_a[7:4]} + {2'b00, i_b[7:4]} + {5'd0, (add_lo > 6'd15)};
        add_mid = {add_hi[3:0], 4'h0};
        if (add_hi > bcd_alu_pkg::DIGIT_MAX) begin
            add_hi = add_hi + bcd_alu_pkg::DIGIT_ADJ;
        end
    end

    // decimal subtract: take 6 from each digit that borrowed
    always_comb begin
        sub_lo = {1'b0, i_a[3:0]} - {1'b0, i_b[3:0]} - {4'd0, borrow};
        sub_hi = {1'b0, i_a[7:4]} - {1'b0, i_b[7:4]};
        if (sub_lo[4]) begin
            sub_lo = sub_lo - bcd_alu_pkg::DIGIT_ADJ[4:0];
            sub_hi = sub_hi - 5'd1;
        end
        if (sub_hi[4]) begin
            sub_hi = sub_hi - bcd_alu_pkg::DIGIT_ADJ[4:0];
        end
    end

    // result and flag select
    always_comb begin
        if (i_sub) begin
            o_res.n = sub_bin[7];
            o_res.z = (sub_bin[7:0] == 8'h00);
            o_res.c = ~sub_bin[8];
            o_res.v = (i_a[7] ^ i_b[7]) & (i_a[7] ^ sub_bin[7]);
            o_res.res = i_d ? {sub_hi[3:0], sub_lo[3:0]} : sub_bin[7:0];
        end else if (i_d) begin
            o_res.n = add_mid[7];
            o_res.z = (add_bin[7:0] == 8'h00);
            o_res.c = (add_hi > 6'd15);
            o_res.v = ~(i_a[7] ^ i_b[7]) & (i_a[7] ^ add_mid[7]);
            o_res.res = {add_hi[3:0], add_lo[3:0]};
        end else begin
            o_res.n = add_bin[7];
            o_res.z = (add_bin[7:0] == 8'h00);
            o_res.c = add_bin[8];
            o_res.v = ~(i_a[7] ^ i_b[7]) & (i_a[7] ^ add_bin[7]);
            o_res.res = add_bin[7:0];
        end
    end

endmodule

@@ sv/bcd_alu_exec.sv @@
// operation decode and result select for one word
// depends on bcd_alu_pkg and bcd_alu_addsub
module bcd_alu_exec (
    input  bcd_alu_pkg::t_alu_in  i_word,
    output bcd_alu_pkg::t_alu_res o_word
);

    bcd_alu_pkg::t_arith_res arith;
    bcd_alu_pkg::t_alu_op    op;
    logic [8:0]              cmp_diff;

    assign op       = bcd_alu_pkg::t_alu_op'(i_word.op);
    assign cmp_diff = {1'b0, i_word.a} - {1'b0, i_word.b};

    bcd_alu_addsub u_addsub (
        .i_sub (op == bcd_alu_pkg::OP_SBC),
        .i_a   (i_word.a),
        .i_b   (i_word.b),
        .i_c   (i_word.c),
        .i_d   (i_word.d),
        .o_res (arith)
    );

    // per-operation byte and flags
    always_comb begin
        logic nz;
        nz          = 1'b0;
        o_word.res  = i_word.a;
        o_word.n    = 1'b0;
        o_word.z    = 1'b0;
        o_word.c    = i_word.c;
        o_word.v    = 1'b0;
        o_word.mask = 4'b0000;
        case (op)
            bcd_alu_pkg::OP_ADC, bcd_alu_pkg::OP_SBC: begin
                o_word.res  = arith.res;
                o_word.n    = arith.n;
                o_word.z    = arith.z;
                o_word.c    = arith.c;
                o_word.v    = arith.v;
                o_word.mask = bcd_alu_pkg::FLG_N | bcd_alu_pkg::FLG_Z
                            | bcd_alu_pkg::FLG_V | bcd_alu_pkg::FLG_C;
            end
            bcd_alu_pkg::OP_AND: begin
                o_word.res  = i_word.a & i_word.b;
                nz          = 1'b1;
            end
            bcd_alu_pkg::OP_ORA: begin
                o_word.res  = i_word.a | i_word.b;
                nz          = 1'b1;
            end
            bcd_alu_pkg::OP_EOR: begin
                o_word.res  = i_word.a ^ i_word.b;
                nz          = 1'b1;
            end
            bcd_alu_pkg::OP_ASL: begin
                o_word.res  = {i_word.b[6:0], 1'b0};
                o_word.c    = i_word.b[7];
                nz          = 1'b1;
                o_word.mask = bcd_alu_pkg::FLG_C;
            end
            bcd_alu_pkg::OP_LSR: begin
                o_word.res  = {1'b0, i_word.b[7:1]};
                o_word.c    = i_word.b[0];
                nz          = 1'b1;
                o_word.mask = bcd_alu_pkg::FLG_C;
            end
            bcd_alu_pkg::OP_ROL: begin
                o_word.res  = {i_word.b[6:0], i_word.c};
                o_word.c    = i_word.b[7];
                nz          = 1'b1;
                o_word.mask = bcd_alu_pkg::FLG_C;
            end
            bcd_alu_pkg::OP_ROR: begin
                o_word.res  = {i_word.c, i_word.b[7:1]};
                o_word.c    = i_word.b[0];
                nz          = 1'b1;
                o_word.mask = bcd_alu_pkg::FLG_C;
            end
            bcd_alu_pkg::OP_CMP: begin
                o_word.n    = cmp_diff[7];
                o_word.z    = (cmp_diff[7:0] == 8'h00);
                o_word.c    = ~cmp_diff[8];
                o_word.mask = bcd_alu_pkg::FLG_N | bcd_alu_pkg::FLG_Z
                            | bcd_alu_pkg::FLG_C;
            end
            bcd_alu_pkg::OP_BIT: begin
                o_word.z    = ((i_word.a & i_word.b) == 8'h00);
                o_word.n    = i_word.b[7];
                o_word.v    = i_word.b[6];
                o_word.mask = bcd_alu_pkg::FLG_N | bcd_alu_pkg::FLG_Z
                            | bcd_alu_pkg::FLG_V;
            end
            bcd_alu_pkg::OP_INC: begin
                o_word.res  = i_word.b + 8'd1;
                nz          = 1'b1;
            end
            bcd_alu_pkg::OP_DEC: begin
                o_word.res  = i_word.b - 8'd1;
                nz          = 1'b1;
            end
            bcd_alu_pkg::OP_PASS: begin
                o_word.res  = i_word.b;
                nz          = 1'b1;
            end
            default: begin
                o_word.res  = i_word.a;
            end
        endcase
        // n and z from the result byte for logic, shift, step and pass operations
        if (nz) begin
            o_word.n    = o_word.res[7];
            o_word.z    = (o_word.res == 8'h00);
            o_word.mask = o_word.mask | bcd_alu_pkg::FLG_N | bcd_alu_pkg::FLG_Z;
        end
    end

endmodule

@@ sv/eight_bit_bcd_alu_core.sv @@
// eight-bit alu with binary and packed bcd add/subtract
// depends on bcd_alu_pkg and bcd_alu_exec
//
// usage:
//   input channel: i_valid / o_ready with operation, operand_a, operand_b,
//   carry_in and decimal_mode; a word is taken when both are high.
//   output channel: o_valid / i_ready with the result byte, the n, z, c, v
//   flags and the mask of flags the operation changes.
//   a word passes an input register, then the alu logic, then a result
//   register; o_valid rises when the result register takes the word.
//   throughput is one word per cycle while the receiver keeps i_ready high;
//   each register loads when it is empty or the one ahead takes its word.
//   when the receiver stalls, the result register holds its word, the input
//   register fills behind it and o_ready drops only once both are full;
//   nothing is lost or repeated.
//   reset clears both valid bits; no other state is kept between words.
module eight_bit_bcd_alu_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [3:0] i_operation,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    input  logic       i_decimal_mode,
    // output channel
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_result_byte,
    output logic       o_negative_flag,
    output logic       o_zero_flag,
    output logic       o_carry_flag,
    output logic       o_overflow_flag,
    output logic [3:0] o_flags_changed
);

    bcd_alu_pkg::t_alu_in  r_in;
    logic                  r_in_valid;
    bcd_alu_pkg::t_alu_res r_out;
    logic                  r_out_valid;
    bcd_alu_pkg::t_alu_res n_out;
    logic                  out_load;
    logic                  in_load;

    // stage advance
    assign out_load = ~r_out_valid | i_ready;
    assign in_load  = ~r_in_valid | out_load;
    assign o_ready  = in_load;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_load) begin
                r_in_valid <= i_valid;
            end
            if (out_load) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (in_load && i_valid) begin
            r_in.op <= i_operation;
            r_in.a  <= i_operand_a;
            r_in.b  <= i_operand_b;
            r_in.c  <= i_carry_in;
            r_in.d  <= i_decimal_mode;
        end
    end

    // alu logic
    bcd_alu_exec u_exec (
        .i_word (r_in),
        .o_word (n_out)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_byte   = r_out.res;
    assign o_negative_flag = r_out.n;
    assign o_zero_flag     = r_out.z;
    assign o_carry_flag    = r_out.c;
    assign o_overflow_flag = r_out.v;
    assign o_flags_changed = r_out.mask;

endmodule
